[rtl/hmma_pkg.sv]
// Shared types and constants for the handheld memory map access block.
// No dependencies; every other file in rtl/ imports this package.
package hmma_pkg;

    // Region order doubles as the decode priority and the base register index
    localparam int REGION_COUNT = 6;

    // Offset into any region (covers regions of up to 1 MiB)
    localparam int OFF_W = 20;

    // Row counter for the clearing pass (1 MiB / 4 lanes)
    localparam int CLR_ROW_W = 18;

    typedef enum logic [2:0] {
        REG_WORK     = 3'd0,
        REG_INTERNAL = 3'd1,
        REG_IO       = 3'd2,
        REG_PALETTE  = 3'd3,
        REG_VIDEO    = 3'd4,
        REG_OBJECT   = 3'd5
    } t_region;

    // Command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_RSVD = 2'd3;

    typedef logic [REGION_COUNT-1:0][31:0] t_bases;

    localparam t_bases BASE_RESET = {
        32'h0700_0000, 32'h0600_0000, 32'h0500_0000,
        32'h0400_0000, 32'h0300_0000, 32'h0200_0000
    };

    // Request to one region's byte lanes
    typedef struct packed {
        logic             rd;
        logic             we;
        logic [OFF_W-1:0] offset;
        logic [1:0]       size;
        logic [31:0]      wdata;
    } t_acc;

    // Clearing pass row, shared by all regions
    typedef struct packed {
        logic                 active;
        logic [CLR_ROW_W-1:0] row;
    } t_clr;

endpackage

[rtl/hmma_decode.sv]
// Address decoder: six parallel range checks and a fixed-priority pick.
// Depends on hmma_pkg.
module hmma_decode import hmma_pkg::*; #(
    parameter int WORK_RAM_BYTES     = 262144,
    parameter int INTERNAL_RAM_BYTES = 32768,
    parameter int IO_BYTES           = 1024,
    parameter int PALETTE_BYTES      = 1024,
    parameter int VIDEO_RAM_BYTES    = 98304,
    parameter int OBJECT_RAM_BYTES   = 1024
) (
    input  t_bases           i_bases,
    input  logic [1:0]       i_size,
    input  logic [31:0]      i_addr,
    output logic             o_ok,
    output t_region          o_region,
    output logic [OFF_W-1:0] o_offset
);

    localparam int REGION_BYTES [REGION_COUNT] = '{
        WORK_RAM_BYTES, INTERNAL_RAM_BYTES, IO_BYTES,
        PALETTE_BYTES, VIDEO_RAM_BYTES, OBJECT_RAM_BYTES
    };

    logic [2:0]              nbytes;
    logic [31:0]             off   [REGION_COUNT];
    logic [REGION_COUNT-1:0] hit;

    // Per-region fit: addr >= base, offset + length <= size, and size not reserved
    always_comb begin
        nbytes = 3'd1 << i_size;
        for (int r = 0; r < REGION_COUNT; r++) begin
            off[r] = i_addr - i_bases[r];
            hit[r] = (i_addr >= i_bases[r]) &&
                     (({1'b0, off[r]} + 33'(nbytes)) <= 33'(REGION_BYTES[r])) &&
                     (i_size != SZ_RSVD);
        end
    end

    // Earliest region in the order wins
    always_comb begin
        o_ok     = |hit;
        o_region = REG_WORK;
        o_offset = '0;
        for (int r = REGION_COUNT - 1; r >= 0; r--) begin
            if (hit[r]) begin
                o_region = t_region'(3'(r));
                o_offset = OFF_W'(off[r]);
            end
        end
    end

endmodule

[rtl/hmma_region.sv]
// One memory region held as four byte-lane RAMs with registered read data.
// Depends on hmma_pkg (t_acc, t_clr, OFF_W).
module hmma_region import hmma_pkg::*; #(
    parameter int BYTES = 1024
) (
    input  logic        i_clk,
    input  t_acc        i_acc,
    input  t_clr        i_clr,
    output logic [31:0] o_lanes
);

    localparam int ROWS  = (BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [2:0]       nbytes;
    logic [1:0]       lane_pos [4];
    logic [OFF_W-1:0] idx      [4];
    logic [ROW_W-1:0] row      [4];
    logic             act      [4];
    logic [7:0]       wbyte    [4];
    logic             clr_hit;
    logic [ROW_W-1:0] clr_row;

    // Lane l holds bytes with offset mod 4 == l; lane_pos is the byte's place in the request
    always_comb begin
        nbytes = 3'd1 << i_acc.size;
        for (int l = 0; l < 4; l++) begin
            lane_pos[l] = 2'(l) - i_acc.offset[1:0];
            idx[l]      = i_acc.offset + OFF_W'(lane_pos[l]);
            row[l]      = ROW_W'(idx[l] >> 2);
            act[l]      = ({1'b0, lane_pos[l]} < nbytes);
            wbyte[l]    = 8'(i_acc.wdata >> {lane_pos[l], 3'b000});
        end
        clr_hit = i_clr.active && (32'(i_clr.row) < 32'(ROWS));
        clr_row = ROW_W'(i_clr.row);
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [7:0] r_mem [ROWS];
        logic [7:0] r_rdata;

        // Write port: clearing pass or request byte
        always_ff @(posedge i_clk) begin
            if (clr_hit) begin
                r_mem[clr_row] <= '0;
            end else if (i_acc.we && act[l]) begin
                r_mem[row[l]] <= wbyte[l];
            end
        end

        // Read port with registered data, holds when not enabled
        always_ff @(posedge i_clk) begin
            if (i_acc.rd) begin
                r_rdata <= r_mem[row[l]];
            end
        end

        assign o_lanes[8*l +: 8] = r_rdata;
    end

endmodule

[rtl/handheld_memory_map_access_top.sv]
// A request is registered in the decode stage, then in the memory stage, which drives the result.
// Throughput: one request per cycle; the whole pipeline stalls on result backpressure.
// Reset: base registers return to their defaults, then a clearing pass zeroes the
// memories one row (four bytes) per cycle, ceil(largest region / 4) rows, 65536 at
// default sizes; no request is accepted until it ends. Config writes are always taken.
module handheld_memory_map_access_top import hmma_pkg::*; #(
    parameter int WORK_RAM_BYTES     = 262144,
    parameter int INTERNAL_RAM_BYTES = 32768,
    parameter int IO_BYTES           = 1024,
    parameter int PALETTE_BYTES      = 1024,
    parameter int VIDEO_RAM_BYTES    = 98304,
    parameter int OBJECT_RAM_BYTES   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [31:0] o_read_data,
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int REGION_BYTES [REGION_COUNT] = '{
        WORK_RAM_BYTES, INTERNAL_RAM_BYTES, IO_BYTES,
        PALETTE_BYTES, VIDEO_RAM_BYTES, OBJECT_RAM_BYTES
    };
    localparam int MAX_A     = (WORK_RAM_BYTES > INTERNAL_RAM_BYTES) ?
                               WORK_RAM_BYTES : INTERNAL_RAM_BYTES;
    localparam int MAX_B     = (IO_BYTES > PALETTE_BYTES) ? IO_BYTES : PALETTE_BYTES;
    localparam int MAX_C     = (VIDEO_RAM_BYTES > OBJECT_RAM_BYTES) ?
                               VIDEO_RAM_BYTES : OBJECT_RAM_BYTES;
    localparam int MAX_AB    = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int MAX_BYTES = (MAX_AB > MAX_C) ? MAX_AB : MAX_C;
    localparam int MAX_ROWS  = (MAX_BYTES + 3) / 4;
    localparam logic [CLR_ROW_W-1:0] CLR_LAST = CLR_ROW_W'(MAX_ROWS - 1);

    t_bases               r_base;
    logic                 r_clr_busy, n_clr_busy;
    logic [CLR_ROW_W-1:0] r_clr_row, n_clr_row;

    // Decode stage
    logic                 r_v1, r_ok1, r_cmd1;
    logic [1:0]           r_size1;
    t_region              r_region1;
    logic [OFF_W-1:0]     r_off1;
    logic [31:0]          r_wdata1;

    // Memory stage / result
    logic                 r_v2, r_ok2, r_cmd2;
    logic [1:0]           r_size2;
    t_region              r_region2;
    logic [1:0]           r_lane2;

    logic                 adv;
    logic                 dec_ok;
    t_region              dec_region;
    logic [OFF_W-1:0]     dec_offset;
    t_acc                 acc [REGION_COUNT];
    t_clr                 clr;
    logic [31:0]          lanes [REGION_COUNT];
    logic [31:0]          sel_lanes;
    logic [63:0]          rot_src;
    logic [31:0]          rot;
    logic [31:0]          mask;

    assign adv         = !r_v2 || i_out_ready;
    assign o_in_ready  = adv && !r_clr_busy;
    assign o_cfg_ready = 1'b1;

    // Base address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid && (i_cfg_index < 3'(REGION_COUNT))) begin
            r_base[i_cfg_index] <= i_cfg_data;
        end
    end

    // Clearing pass after reset
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_row  = r_clr_row;
        if (r_clr_busy) begin
            n_clr_row = r_clr_row + 1'b1;
            if (r_clr_row == CLR_LAST) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_row  <= n_clr_row;
        end
    end

    assign clr.active = r_clr_busy;
    assign clr.row    = r_clr_row;

    hmma_decode #(
        .WORK_RAM_BYTES     (WORK_RAM_BYTES),
        .INTERNAL_RAM_BYTES (INTERNAL_RAM_BYTES),
        .IO_BYTES           (IO_BYTES),
        .PALETTE_BYTES      (PALETTE_BYTES),
        .VIDEO_RAM_BYTES    (VIDEO_RAM_BYTES),
        .OBJECT_RAM_BYTES   (OBJECT_RAM_BYTES)
    ) u_decode (
        .i_bases  (r_base),
        .i_size   (i_access_size),
        .i_addr   (i_address),
        .o_ok     (dec_ok),
        .o_region (dec_region),
        .o_offset (dec_offset)
    );

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid && o_in_ready;
            r_v2 <= r_v1;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok1     <= dec_ok;
            r_cmd1    <= i_command;
            r_size1   <= i_access_size;
            r_region1 <= dec_region;
            r_off1    <= dec_offset;
            r_wdata1  <= i_write_data;
            r_ok2     <= r_ok1;
            r_cmd2    <= r_cmd1;
            r_size2   <= r_size1;
            r_region2 <= r_region1;
            r_lane2   <= r_off1[1:0];
        end
    end

    // Route the decoded request to the hit region only
    always_comb begin
        for (int r = 0; r < REGION_COUNT; r++) begin
            acc[r].rd     = adv && r_v1 && r_ok1 && (r_cmd1 == CMD_READ) &&
                            (r_region1 == t_region'(3'(r)));
            acc[r].we     = adv && r_v1 && r_ok1 && (r_cmd1 == CMD_WRITE) &&
                            (r_region1 == t_region'(3'(r)));
            acc[r].offset = r_off1;
            acc[r].size   = r_size1;
            acc[r].wdata  = r_wdata1;
        end
    end

    for (genvar g = 0; g < REGION_COUNT; g++) begin : g_region
        hmma_region #(
            .BYTES (REGION_BYTES[g])
        ) u_region (
            .i_clk   (i_clk),
            .i_acc   (acc[g]),
            .i_clr   (clr),
            .o_lanes (lanes[g])
        );
    end

    // Rotate lanes back into request byte order and trim to size
    always_comb begin
        sel_lanes = lanes[r_region2];
        rot_src   = {sel_lanes, sel_lanes};
        rot       = 32'(rot_src >> {r_lane2, 3'b000});
        case (r_size2)
            SZ_BYTE: mask = 32'h0000_00FF;
            SZ_HALF: mask = 32'h0000_FFFF;
            SZ_WORD: mask = 32'hFFFF_FFFF;
            default: mask = 32'h0000_0000;
        endcase
    end

    assign o_out_valid = r_v2;
    assign o_ok        = r_ok2;
    assign o_read_data = (r_ok2 && (r_cmd2 == CMD_READ)) ? (rot & mask) : 32'h0;

endmodule
